// File: rtl/core/bpdc_pkg.sv
`default_nettype none

package bpdc_pkg;

  // Field widths of the words on the three channels.
  localparam int FACE_W     = 40;
  localparam int RATE_W     = 26;
  localparam int FREQ_W     = 4;
  localparam int COUNT_W    = 11;
  localparam int YIELD_W    = 32;
  localparam int PRICE_W    = 48;
  localparam int DUR_W      = 32;
  localparam int CONV_W     = 40;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 40;

  localparam int MAX_PAYMENTS_DEF = 1024;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FACE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd3;

  localparam logic [FACE_W-1:0]  FACE_RESET  = 40'd6553600;
  localparam logic [RATE_W-1:0]  RATE_RESET  = '0;
  localparam logic [FREQ_W-1:0]  FREQ_RESET  = 4'd1;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1;

  // Shared divider geometry: the dividend is left aligned in DIV_NUM_W bits.
  localparam int DIV_NUM_W  = 128;
  localparam int DIV_DEN_W  = 64;
  localparam int DIV_QUO_W  = 64;
  localparam int DIV_STEP_W = 7;

  typedef struct packed {
    logic                  start;
    logic [DIV_NUM_W-1:0]  num;
    logic [DIV_DEN_W-1:0]  den;
    logic [DIV_STEP_W-1:0] steps;
  } div_cmd_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_QUO_W-1:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/bpdc_in_if.sv
`default_nettype none

interface bpdc_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [bpdc_pkg::YIELD_W-1:0] yield_rate;

  modport source (output valid, output yield_rate, input ready);
  modport sink   (input valid, input yield_rate, output ready);
endinterface

`default_nettype wire

// File: rtl/core/bpdc_out_if.sv
`default_nettype none

interface bpdc_out_if;
  logic                          valid;
  logic                          ready;
  logic [bpdc_pkg::PRICE_W-1:0]  price;
  logic [bpdc_pkg::DUR_W-1:0]    macaulay_duration;
  logic [bpdc_pkg::DUR_W-1:0]    modified_duration;
  logic [bpdc_pkg::CONV_W-1:0]   convexity_value;
  logic                          status;

  modport source (output valid, output price, output macaulay_duration,
                  output modified_duration, output convexity_value, output status,
                  input ready);
  modport sink   (input valid, input price, input macaulay_duration,
                  input modified_duration, input convexity_value, input status,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/core/bpdc_cfg_if.sv
`default_nettype none

interface bpdc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bpdc_pkg::CFG_IDX_W-1:0]   index;
  logic [bpdc_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/bpdc_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. Quotient bits that fall
// off the top mark an overflow and the result saturates to all ones.
module bpdc_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bpdc_pkg::div_cmd_t cmd,
  output bpdc_pkg::div_rsp_t      rsp
);

  logic [bpdc_pkg::DIV_NUM_W-1:0]  num_r;
  logic [bpdc_pkg::DIV_DEN_W-1:0]  den_r;
  logic [bpdc_pkg::DIV_DEN_W-1:0]  rem_r;
  logic [bpdc_pkg::DIV_QUO_W-1:0]  quo_r;
  logic                            ovf_r;
  logic [bpdc_pkg::DIV_STEP_W-1:0] cnt_r;
  logic                            busy_r;
  logic                            done_r;

  logic [bpdc_pkg::DIV_DEN_W:0]    rem_sh;
  logic [bpdc_pkg::DIV_DEN_W:0]    rem_sub;
  logic                            fits;
  logic [bpdc_pkg::DIV_DEN_W-1:0]  rem_step;

  always_comb begin
    rem_sh   = {rem_r, num_r[bpdc_pkg::DIV_NUM_W-1]};
    rem_sub  = rem_sh - {1'b0, den_r};
    fits     = (rem_sh >= {1'b0, den_r});
    rem_step = fits ? rem_sub[bpdc_pkg::DIV_DEN_W-1:0] : rem_sh[bpdc_pkg::DIV_DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == bpdc_pkg::DIV_STEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      num_r <= cmd.num;
      den_r <= cmd.den;
      rem_r <= '0;
      quo_r <= '0;
      ovf_r <= 1'b0;
      cnt_r <= cmd.steps;
    end else if (busy_r) begin
      num_r <= {num_r[bpdc_pkg::DIV_NUM_W-2:0], 1'b0};
      rem_r <= rem_step;
      quo_r <= {quo_r[bpdc_pkg::DIV_QUO_W-2:0], fits};
      ovf_r <= ovf_r | quo_r[bpdc_pkg::DIV_QUO_W-1];
      cnt_r <= cnt_r - bpdc_pkg::DIV_STEP_W'(1);
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = ovf_r ? '1 : quo_r;

endmodule

`default_nettype wire

// File: rtl/core/bond_price_duration_convexity.sv
// Fixed-coupon bond analytics: one annual yield word in, one result word out
// carrying price, Macaulay duration, modified duration, convexity and status.
// The bond terms (face value, coupon rate, payments per year, payment count)
// are written through the configuration channel, which is always ready; write
// it only while the block is idle.
// The input channel is ready only while the sequencer is idle. One word then
// runs through a single shared 34x34 multiplier and a shared one bit per cycle
// divider. The work runs in order: the discount factor division, its
// normalization, the coupon division, four multiplier passes per payment, then
// two divisions by the sum of present values and two by the payment frequency
// terms, plus four 4-pass wide products. The payment loop on the multiplier
// dominates for many payments. A yield at or below -100 percent per period
// is answered straight from the done state with status set and all values zero.
// The result sits in an output register; while the receiver stalls, the next
// word cannot start its final hand-off, and the block waits holding its result.
// Reset restores the register defaults (face value 100.0, one payment) and
// empties the block.
`default_nettype none

module bond_price_duration_convexity #(
  parameter int MAX_PAYMENTS = bpdc_pkg::MAX_PAYMENTS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bpdc_in_if.sink    in_ch,
  bpdc_out_if.source out_ch,
  bpdc_cfg_if.sink   cfg_ch
);

  localparam int KW  = $clog2(MAX_PAYMENTS + 1);
  localparam int KKW = 2 * KW;
  localparam int MW  = 34;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DM   = 4'd1;
  localparam logic [3:0] S_NORM = 4'd2;
  localparam logic [3:0] S_CPN  = 4'd3;
  localparam logic [3:0] S_LD   = 4'd4;
  localparam logic [3:0] S_LW   = 4'd5;
  localparam logic [3:0] S_LB   = 4'd6;
  localparam logic [3:0] S_LE   = 4'd7;
  localparam logic [3:0] S_LACC = 4'd8;
  localparam logic [3:0] S_POST = 4'd9;
  localparam logic [3:0] S_MUL  = 4'd10;
  localparam logic [3:0] S_DIVW = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  localparam logic [3:0] J_START = 4'd0;
  localparam logic [3:0] J_PRICE = 4'd1;
  localparam logic [3:0] J_MAC1  = 4'd2;
  localparam logic [3:0] J_MAC2  = 4'd3;
  localparam logic [3:0] J_MOD   = 4'd4;
  localparam logic [3:0] J_CVX1  = 4'd5;
  localparam logic [3:0] J_CVX2  = 4'd6;
  localparam logic [3:0] J_CVX3  = 4'd7;
  localparam logic [3:0] J_CVX4  = 4'd8;

  localparam logic [26:0] ONE_Q24 = 27'd16777216;

  // floor(p * 2^-sh) saturated at maxv; a negative sh shifts left.
  function automatic logic [63:0] shift_sat(input logic [127:0] p,
                                            input logic signed [31:0] sh,
                                            input logic [63:0] maxv);
    logic [127:0] v;
    logic [5:0]   la;
    logic [63:0]  r;
    v  = '0;
    la = '0;
    r  = '0;
    if (sh >= 32'sd128) begin
      r = '0;
    end else if (sh >= 32'sd0) begin
      v = p >> sh[6:0];
      if (v[127:64] != '0) r = maxv;
      else r = (v[63:0] > maxv) ? maxv : v[63:0];
    end else if (p == '0) begin
      r = '0;
    end else if (p[127:64] != '0 || sh <= -32'sd64) begin
      r = maxv;
    end else begin
      la = 6'(-sh);
      if ((p[63:0] >> (7'd64 - {1'b0, la})) != '0) begin
        r = maxv;
      end else begin
        v[63:0] = p[63:0] << la;
        r = (v[63:0] > maxv) ? maxv : v[63:0];
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] shr_c(input logic [63:0] x, input logic [32:0] amt);
    return (amt >= 33'd64) ? '0 : (x >> amt[5:0]);
  endfunction

  // Configuration registers.
  logic [bpdc_pkg::FACE_W-1:0]  face_r;
  logic [bpdc_pkg::RATE_W-1:0]  rate_r;
  logic [bpdc_pkg::FREQ_W-1:0]  freq_r;
  logic [bpdc_pkg::COUNT_W-1:0] count_r;

  // Sequencer and datapath.
  logic [3:0]         state_r, state_nxt;
  logic [3:0]         job_r, job_nxt;
  logic [3:0]         f_r, f_nxt;
  logic [KW-1:0]      n_r, n_nxt;
  logic [63:0]        dm_r, dm_nxt;
  logic signed [7:0]  ed_r, ed_nxt;
  logic [25:0]        coupon_r, coupon_nxt;
  logic [31:0]        dk_r, dk_nxt;
  logic signed [31:0] edk_r, edk_nxt;
  logic [KW-1:0]      k_r, k_nxt;
  logic [KKW-1:0]     kk_r, kk_nxt;
  logic [26:0]        w_r, w_nxt;
  logic [63:0]        b_r, b_nxt;
  logic [63:0]        e_r, e_nxt;
  logic               pend_r, pend_nxt;
  logic               first_r, first_nxt;
  logic [63:0]        s_r, s_nxt;
  logic [63:0]        t_r, t_nxt;
  logic [63:0]        c_r, c_nxt;
  logic signed [31:0] es_r, es_nxt;
  logic [63:0]        ma_r, ma_nxt;
  logic [63:0]        mb_r, mb_nxt;
  logic [127:0]       acc_r, acc_nxt;
  logic [1:0]         ph_r, ph_nxt;
  bpdc_pkg::div_cmd_t div_cmd_r, div_cmd_nxt;
  bpdc_pkg::div_rsp_t div_rsp;
  logic [47:0]        price_r, price_nxt;
  logic [31:0]        mac_r, mac_nxt;
  logic [31:0]        mod_r, mod_nxt;
  logic [39:0]        conv_r, conv_nxt;
  logic               status_r, status_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_load;
  logic [47:0]        out_price_r;
  logic [31:0]        out_mac_r;
  logic [31:0]        out_mod_r;
  logic [39:0]        out_conv_r;
  logic               out_status_r;

  // Shared multiplier.
  logic [MW-1:0]      mul_a, mul_b;
  logic [2*MW-1:0]    prod;
  logic [31:0]        part_a, part_b;
  logic [127:0]       part_sh;

  // Helpers.
  logic               in_fire;
  logic [3:0]         f_in;
  logic [31:0]        n_calc;
  logic signed [33:0] den;
  logic [26:0]        cf;
  logic [7:0]         ff;
  logic [63:0]        s_fix;
  logic signed [31:0] sat_sh;
  logic [63:0]        sat_max;
  logic [63:0]        sat_val;

  // Accumulate step.
  logic signed [31:0] et;
  logic signed [32:0] ediff;
  logic [32:0]        dneg;
  logic [63:0]        sa, ta, ca, aa, ba, ea, ns, nt, nc;
  logic signed [31:0] es_a;

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_r  <= bpdc_pkg::FACE_RESET;
      rate_r  <= bpdc_pkg::RATE_RESET;
      freq_r  <= bpdc_pkg::FREQ_RESET;
      count_r <= bpdc_pkg::COUNT_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        bpdc_pkg::CFG_FACE:  face_r  <= cfg_ch.data;
        bpdc_pkg::CFG_RATE:  rate_r  <= cfg_ch.data[bpdc_pkg::RATE_W-1:0];
        bpdc_pkg::CFG_FREQ:  freq_r  <= cfg_ch.data[bpdc_pkg::FREQ_W-1:0];
        bpdc_pkg::CFG_COUNT: count_r <= cfg_ch.data[bpdc_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  bpdc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (div_cmd_r),
    .rsp   (div_rsp)
  );

  always_comb begin
    f_in   = (freq_r == '0) ? 4'd1 : freq_r;
    n_calc = (count_r == '0) ? 32'd1 :
             ((32'(count_r) > 32'(MAX_PAYMENTS)) ? 32'(MAX_PAYMENTS) : 32'(count_r));
    den    = $signed({6'b0, f_in, 24'b0}) +
             $signed({{2{in_ch.yield_rate[31]}}, in_ch.yield_rate});
    cf     = {1'b0, coupon_r} + ((k_r == n_r) ? ONE_Q24 : 27'd0);
    ff     = {4'b0, f_r} * {4'b0, f_r};
    s_fix  = (s_r == '0) ? 64'd1 : s_r;
  end

  // Multiplier operand selection.
  always_comb begin
    part_a = ph_r[0] ? ma_r[63:32] : ma_r[31:0];
    part_b = ph_r[1] ? mb_r[63:32] : mb_r[31:0];
    case (state_r)
      S_LD: begin
        mul_a = {2'b0, dk_r};
        mul_b = {2'b0, dm_r[31:0]};
      end
      S_LW: begin
        mul_a = MW'(cf);
        mul_b = {2'b0, dk_r};
      end
      S_LB: begin
        mul_a = MW'(w_r);
        mul_b = MW'(k_r);
      end
      S_LE: begin
        mul_a = MW'(w_r);
        mul_b = MW'(kk_r);
      end
      S_MUL: begin
        mul_a = {2'b0, part_a};
        mul_b = {2'b0, part_b};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;
    case (2'(ph_r[0]) + 2'(ph_r[1]))
      2'd0:    part_sh = {64'b0, prod[63:0]};
      2'd1:    part_sh = {32'b0, prod[63:0], 32'b0};
      default: part_sh = {prod[63:0], 64'b0};
    endcase
  end

  // Align the new term to the shared exponent of the sums, add, renormalize.
  always_comb begin
    et    = edk_r - 32'sd8;
    ediff = {et[31], et} - {es_r[31], es_r};
    dneg  = -ediff;
    sa    = s_r;
    ta    = t_r;
    ca    = c_r;
    aa    = 64'(w_r);
    ba    = b_r;
    ea    = e_r;
    es_a  = es_r;
    if (first_r) begin
      es_a = et;
    end else if (ediff[32]) begin
      sa   = shr_c(s_r, dneg);
      ta   = shr_c(t_r, dneg);
      ca   = shr_c(c_r, dneg);
      es_a = et;
    end else if (ediff != '0) begin
      aa = shr_c(aa, ediff);
      ba = shr_c(b_r, ediff);
      ea = shr_c(e_r, ediff);
    end
    ns = sa + aa;
    nt = ta + ba;
    nc = ca + ea;
    if ((|ns[63:61]) || (|nt[63:61]) || (|nc[63:61])) begin
      ns   = ns >> 1;
      nt   = nt >> 1;
      nc   = nc >> 1;
      es_a = es_a - 32'sd1;
    end
  end

  // One shared saturating shifter for the final scaling steps.
  always_comb begin
    sat_sh = (job_r == J_PRICE) ? es_r : {{24{ed_r[7]}}, ed_r};
    case (job_r)
      J_PRICE: sat_max = 64'h0000_FFFF_FFFF_FFFF;
      J_MOD:   sat_max = 64'h0000_0000_FFFF_FFFF;
      J_CVX3:  sat_max = 64'h4000_0000_0000_0000;
      J_CVX4:  sat_max = 64'h0000_00FF_FFFF_FFFF;
      default: sat_max = '1;
    endcase
    sat_val = shift_sat(acc_r, sat_sh, sat_max);
  end

  // Sequencer.
  always_comb begin
    state_nxt   = state_r;
    job_nxt     = job_r;
    f_nxt       = f_r;
    n_nxt       = n_r;
    dm_nxt      = dm_r;
    ed_nxt      = ed_r;
    coupon_nxt  = coupon_r;
    dk_nxt      = dk_r;
    edk_nxt     = edk_r;
    k_nxt       = k_r;
    kk_nxt      = kk_r;
    w_nxt       = w_r;
    b_nxt       = b_r;
    e_nxt       = e_r;
    pend_nxt    = pend_r;
    first_nxt   = first_r;
    s_nxt       = s_r;
    t_nxt       = t_r;
    c_nxt       = c_r;
    es_nxt      = es_r;
    ma_nxt      = ma_r;
    mb_nxt      = mb_r;
    acc_nxt     = acc_r;
    ph_nxt      = ph_r;
    div_cmd_nxt = div_cmd_r;
    div_cmd_nxt.start = 1'b0;
    price_nxt   = price_r;
    mac_nxt     = mac_r;
    mod_nxt     = mod_r;
    conv_nxt    = conv_r;
    status_nxt  = status_r;
    out_load    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          f_nxt = f_in;
          n_nxt = KW'(n_calc);
          if (den[33] || den == '0) begin
            price_nxt  = '0;
            mac_nxt    = '0;
            mod_nxt    = '0;
            conv_nxt   = '0;
            status_nxt = 1'b1;
            state_nxt  = S_DONE;
          end else begin
            status_nxt        = 1'b0;
            div_cmd_nxt.start = 1'b1;
            div_cmd_nxt.num   = {1'b0, f_in, 59'b0, 64'b0};
            div_cmd_nxt.den   = {30'b0, den};
            div_cmd_nxt.steps = 7'd64;
            state_nxt         = S_DM;
          end
        end
      end
      S_DM: begin
        if (div_rsp.done) begin
          dm_nxt    = div_rsp.quo;
          ed_nxt    = 8'sd35;
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        if (dm_r[63:32] != '0) begin
          dm_nxt = dm_r >> 1;
          ed_nxt = ed_r - 8'sd1;
        end else if (!dm_r[31]) begin
          dm_nxt = dm_r << 1;
          ed_nxt = ed_r + 8'sd1;
        end else begin
          div_cmd_nxt.start = 1'b1;
          div_cmd_nxt.num   = {rate_r, 102'b0};
          div_cmd_nxt.den   = {60'b0, f_r};
          div_cmd_nxt.steps = 7'd26;
          state_nxt         = S_CPN;
        end
      end
      S_CPN: begin
        if (div_rsp.done) begin
          coupon_nxt = div_rsp.quo[25:0];
          dk_nxt     = 32'h8000_0000;
          edk_nxt    = 32'sd31;
          k_nxt      = KW'(1);
          kk_nxt     = KKW'(2);
          s_nxt      = '0;
          t_nxt      = '0;
          c_nxt      = '0;
          first_nxt  = 1'b1;
          pend_nxt   = 1'b0;
          state_nxt  = S_LD;
        end
      end
      S_LD: begin
        // Next power of the discount factor, renormalized by at most one bit.
        if (prod[63]) begin
          dk_nxt  = prod[63:32];
          edk_nxt = edk_r + {{24{ed_r[7]}}, ed_r} - 32'sd32;
        end else begin
          dk_nxt  = {prod[62:32], 1'b0};
          edk_nxt = edk_r + {{24{ed_r[7]}}, ed_r} - 32'sd31;
        end
        if (pend_r) begin
          s_nxt     = ns;
          t_nxt     = nt;
          c_nxt     = nc;
          es_nxt    = es_a;
          first_nxt = 1'b0;
          pend_nxt  = 1'b0;
        end
        state_nxt = S_LW;
      end
      S_LW: begin
        w_nxt     = prod[58:32];
        state_nxt = S_LB;
      end
      S_LB: begin
        b_nxt     = prod[63:0];
        state_nxt = S_LE;
      end
      S_LE: begin
        e_nxt    = prod[63:0];
        pend_nxt = 1'b1;
        if (k_r == n_r) begin
          state_nxt = S_LACC;
        end else begin
          k_nxt     = k_r + KW'(1);
          kk_nxt    = kk_r + KKW'({k_r, 1'b0}) + KKW'(2);
          state_nxt = S_LD;
        end
      end
      S_LACC: begin
        s_nxt     = ns;
        t_nxt     = nt;
        c_nxt     = nc;
        es_nxt    = es_a;
        pend_nxt  = 1'b0;
        first_nxt = 1'b0;
        job_nxt   = J_START;
        state_nxt = S_POST;
      end
      S_MUL: begin
        acc_nxt = acc_r + part_sh;
        ph_nxt  = ph_r + 2'd1;
        if (ph_r == 2'd3) state_nxt = S_POST;
      end
      S_DIVW: begin
        if (div_rsp.done) state_nxt = S_POST;
      end
      S_POST: begin
        // Each job takes the result of the previous operation and starts the next; the last stores convexity and ends.
        case (job_r)
          J_START: begin
            s_nxt     = s_fix;
            ma_nxt    = {24'b0, face_r};
            mb_nxt    = s_fix;
            acc_nxt   = '0;
            ph_nxt    = '0;
            job_nxt   = J_PRICE;
            state_nxt = S_MUL;
          end
          J_PRICE: begin
            price_nxt         = sat_val[47:0];
            div_cmd_nxt.start = 1'b1;
            div_cmd_nxt.num   = {t_r, 24'b0, 40'b0};
            div_cmd_nxt.den   = s_r;
            div_cmd_nxt.steps = 7'd88;
            job_nxt           = J_MAC1;
            state_nxt         = S_DIVW;
          end
          J_MAC1: begin
            div_cmd_nxt.start = 1'b1;
            div_cmd_nxt.num   = {div_rsp.quo, 64'b0};
            div_cmd_nxt.den   = {60'b0, f_r};
            div_cmd_nxt.steps = 7'd64;
            job_nxt           = J_MAC2;
            state_nxt         = S_DIVW;
          end
          J_MAC2: begin
            mac_nxt   = (div_rsp.quo[63:32] != '0) ? '1 : div_rsp.quo[31:0];
            ma_nxt    = div_rsp.quo;
            mb_nxt    = {32'b0, dm_r[31:0]};
            acc_nxt   = '0;
            ph_nxt    = '0;
            job_nxt   = J_MOD;
            state_nxt = S_MUL;
          end
          J_MOD: begin
            mod_nxt           = sat_val[31:0];
            div_cmd_nxt.start = 1'b1;
            div_cmd_nxt.num   = {c_r, 24'b0, 40'b0};
            div_cmd_nxt.den   = s_r;
            div_cmd_nxt.steps = 7'd88;
            job_nxt           = J_CVX1;
            state_nxt         = S_DIVW;
          end
          J_CVX1: begin
            div_cmd_nxt.start = 1'b1;
            div_cmd_nxt.num   = {div_rsp.quo, 64'b0};
            div_cmd_nxt.den   = {56'b0, ff};
            div_cmd_nxt.steps = 7'd64;
            job_nxt           = J_CVX2;
            state_nxt         = S_DIVW;
          end
          J_CVX2: begin
            ma_nxt    = div_rsp.quo;
            mb_nxt    = {32'b0, dm_r[31:0]};
            acc_nxt   = '0;
            ph_nxt    = '0;
            job_nxt   = J_CVX3;
            state_nxt = S_MUL;
          end
          J_CVX3: begin
            ma_nxt    = sat_val;
            mb_nxt    = {32'b0, dm_r[31:0]};
            acc_nxt   = '0;
            ph_nxt    = '0;
            job_nxt   = J_CVX4;
            state_nxt = S_MUL;
          end
          default: begin
            conv_nxt  = sat_val[39:0];
            state_nxt = S_DONE;
          end
        endcase
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      job_r       <= J_START;
      out_valid_r <= 1'b0;
      div_cmd_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      job_r       <= job_nxt;
      out_valid_r <= out_valid_nxt;
      div_cmd_r   <= div_cmd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    f_r      <= f_nxt;
    n_r      <= n_nxt;
    dm_r     <= dm_nxt;
    ed_r     <= ed_nxt;
    coupon_r <= coupon_nxt;
    dk_r     <= dk_nxt;
    edk_r    <= edk_nxt;
    k_r      <= k_nxt;
    kk_r     <= kk_nxt;
    w_r      <= w_nxt;
    b_r      <= b_nxt;
    e_r      <= e_nxt;
    pend_r   <= pend_nxt;
    first_r  <= first_nxt;
    s_r      <= s_nxt;
    t_r      <= t_nxt;
    c_r      <= c_nxt;
    es_r     <= es_nxt;
    ma_r     <= ma_nxt;
    mb_r     <= mb_nxt;
    acc_r    <= acc_nxt;
    ph_r     <= ph_nxt;
    price_r  <= price_nxt;
    mac_r    <= mac_nxt;
    mod_r    <= mod_nxt;
    conv_r   <= conv_nxt;
    status_r <= status_nxt;
    if (out_load) begin
      out_price_r  <= price_r;
      out_mac_r    <= mac_r;
      out_mod_r    <= mod_r;
      out_conv_r   <= conv_r;
      out_status_r <= status_r;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.price             = out_price_r;
  assign out_ch.macaulay_duration = out_mac_r;
  assign out_ch.modified_duration = out_mod_r;
  assign out_ch.convexity_value   = out_conv_r;
  assign out_ch.status            = out_status_r;

`ifndef SYNTHESIS
  // The discount factor mantissa must be normalized before the payment loop.
  a_dm_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LD) |-> (dm_r[63:32] == '0 && dm_r[31]))
    else $error("discount factor mantissa not normalized in payment loop");

  // Every power of the discount factor keeps its top bit set.
  a_dk_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LW) |-> dk_r[31])
    else $error("discount power lost normalization");

  // The running sums stay below their limit after each accumulate.
  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LW) |-> (s_r[63:61] == '0 && t_r[63:61] == '0 && c_r[63:61] == '0))
    else $error("weighted sum above its limit");

  // A divider result only arrives while the sequencer waits for one.
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DM || state_r == S_CPN || state_r == S_DIVW))
    else $error("divider finished outside a wait state");

  // An error word carries zero values.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status) |-> (out_ch.price == '0 && out_ch.convexity_value == '0))
    else $error("error word with nonzero values");
`endif

endmodule

`default_nettype wire
